FILE: rtl/json_token_stream_parser_core_macros.svh
// Assertion macros for the JSON token stream parser core.
// Used by the top level only; the macros assume the clock aclk and the reset aresetn.
`ifndef JSON_TOKEN_STREAM_PARSER_CORE_MACROS_SVH
`define JSON_TOKEN_STREAM_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JTSP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JTSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/jtsp_pkg.sv
// Shared types, constants and character-class functions of the JSON token stream parser.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package jtsp_pkg;

    localparam int MAX_NESTING_DEF = 64;
    localparam int PASSES          = 4;   // longest chain of re-dispatches for one byte
    localparam int MAX_RES         = 2;   // most events one transfer can cause
    localparam int QDEPTH          = 4;
    localparam int QAW             = 2;
    localparam int WORD_MAX        = 5;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Bare words packed with the first character in the low byte.
    localparam logic [39:0] WORD_TRUE  = 40'h00_65_75_72_74;
    localparam logic [39:0] WORD_FALSE = 40'h65_73_6C_61_66;
    localparam logic [39:0] WORD_NULL  = 40'h00_6C_6C_75_6E;

    typedef enum logic [3:0] {
        ST_UNKNOWN  = 4'd0,
        ST_DETECT   = 4'd1,
        ST_OBJECT   = 4'd2,
        ST_ARRAY    = 4'd3,
        ST_STRING   = 4'd4,
        ST_NUMERIC  = 4'd5,
        ST_RESERVED = 4'd6,
        ST_KEY      = 4'd7,
        ST_PAIRSEP  = 4'd8,
        ST_ESCAPE   = 4'd10,
        ST_ERROR    = 4'd11
    } st_t;

    typedef enum logic [3:0] {
        EV_BEGOBJ = 4'd0,
        EV_ENDOBJ = 4'd1,
        EV_BEGARR = 4'd2,
        EV_ENDARR = 4'd3,
        EV_KEYCH  = 4'd4,
        EV_KEYEND = 4'd5,
        EV_STRCH  = 4'd6,
        EV_STREND = 4'd7,
        EV_NUMCH  = 4'd8,
        EV_NUMEND = 4'd9,
        EV_TRUE   = 4'd10,
        EV_FALSE  = 4'd11,
        EV_NULL   = 4'd12,
        EV_ERROR  = 4'd13,
        EV_END    = 4'd14
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } step_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_numch(logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2D) || (c == 8'h2B) ||
               (c == 8'h65) || (c == 8'h45) || (c == 8'h2E);
    endfunction

    // Event that closes a bare word.
    function automatic event_t word_event(logic [39:0] wb, logic [2:0] wl, logic wlong);
        event_t ev;
        ev = EV_ERROR;
        if (!wlong) begin
            if ((wl == 3'd4) && (wb == WORD_TRUE)) begin
                ev = EV_TRUE;
            end else if ((wl == 3'd5) && (wb == WORD_FALSE)) begin
                ev = EV_FALSE;
            end else if ((wl == 3'd4) && (wb == WORD_NULL)) begin
                ev = EV_NULL;
            end
        end
        return ev;
    endfunction

    // Appends one event to a step result; further events past the limit are dropped.
    function automatic step_t emit_res(step_t s, event_t ev, logic [7:0] d);
        step_t r;
        r = s;
        if (s.count == 2'd0) begin
            r.r0.ev   = ev;
            r.r0.data = d;
            r.count   = 2'd1;
        end else if (s.count == 2'd1) begin
            r.r1.ev   = ev;
            r.r1.data = d;
            r.count   = 2'd2;
        end
        return r;
    endfunction

endpackage

FILE: rtl/json_token_stream_parser_core.sv
// Top level of the JSON token stream parser: input register, parse engine and result queue.
// Depends on jtsp_pkg, jtsp_engine, jtsp_result_queue and the assertion macro header.
`timescale 1ns / 1ps
`include "json_token_stream_parser_core_macros.svh"

// The core takes one text byte per transfer on the s_ channel, or an end-of-stream mark,
// and delivers JSON tokenizer events on the m_ channel, one event per transfer, with
// m_last set on the final event caused by a given input byte. A byte causes zero, one or
// two events. The sustained rate is one input byte per clock cycle while m_ready stays high
// and each byte causes at most one event; bytes that cause two events slow the input,
// because the single result port moves one event per cycle. An accepted byte is held
// in an input register and processed by the parse logic once the result queue has room for
// all its events. The queue holds four entries and decouples the two channels, so new bytes
// keep flowing while earlier events wait for m_ready, as long as the queue has room.
// Nesting depth is set by MAX_NESTING; a push beyond it reports an error event and the
// core then ignores input until end of stream, which always yields an end event and
// returns the core to its reset state. No clearing pass is needed after reset.
module json_token_stream_parser_core #(
    parameter int MAX_NESTING = jtsp_pkg::MAX_NESTING_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_event_res,
    output logic [7:0] m_data_byte,
    output logic       m_last
);
    import jtsp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    logic       room;
    logic       fire;
    logic       s_xfer;
    step_t      step;
    res_t       head;

    // A held byte is processed once the queue can absorb everything it may produce.
    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; it is only looked at while in_valid_reg is set.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_in_byte;
            in_eos_reg  <= s_end_of_stream;
        end
    end

    jtsp_engine #(
        .MAX_NESTING(MAX_NESTING)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .in_byte       (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .step          (step)
    );

    jtsp_result_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .step    (step),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_event_res = head.ev;
    assign m_data_byte = head.data;
    assign m_last      = head.last;

    // An end-of-stream mark must always produce at least the end event.
    `JTSP_ASSERT_IMPLY(a_eos_has_result, fire && in_eos_reg, step.count != 2'd0, "end of stream without result")
    // With two events in one step, only the second carries the last flag.
    `JTSP_ASSERT_IMPLY(a_last_on_second, fire && (step.count == 2'd2), !step.r0.last && step.r1.last, "last flag misplaced")
    // A byte waiting for queue room stays in the input register unchanged.
    `JTSP_ASSERT_NEXT(a_input_held, in_valid_reg && !fire, in_valid_reg && $stable(in_byte_reg) && $stable(in_eos_reg), "held input lost")

endmodule

FILE: rtl/jtsp_stack.sv
// Nesting stack memory: one write port and two registered read ports with write bypass.
// Depends on jtsp_pkg for the parse state type.
`timescale 1ns / 1ps

module jtsp_stack #(
    parameter int DEPTH = jtsp_pkg::MAX_NESTING_DEF
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  jtsp_pkg::st_t              wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output jtsp_pkg::st_t              rdata_a,
    output jtsp_pkg::st_t              rdata_b
);
    import jtsp_pkg::*;

    st_t mem [DEPTH];
    st_t rd_a_reg;
    st_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the entry written at the same edge returns the new value.
    always_ff @(posedge aclk) begin
        rd_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
        rd_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: rtl/jtsp_engine.sv
// Parse engine: top-of-stack and bare-word registers plus the single-pass step logic.
// Depends on jtsp_pkg and instantiates jtsp_stack for the entries below the top.
`timescale 1ns / 1ps

module jtsp_engine #(
    parameter int MAX_NESTING = jtsp_pkg::MAX_NESTING_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic [7:0]      in_byte,
    input  logic            end_of_stream,
    output jtsp_pkg::step_t step
);
    import jtsp_pkg::*;

    localparam int SP_W = $clog2(MAX_NESTING);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(MAX_NESTING - 1);
    localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
    localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);

    // Working view of the stack: the top, the two entries below it and one pending write.
    typedef struct packed {
        st_t             top;
        st_t             b1;
        st_t             b2;
        logic [SP_W-1:0] sp;
        logic            we;
        logic [SP_W-1:0] waddr;
        st_t             wdata;
        step_t           res;
    } work_t;

    st_t             top_reg;
    logic [SP_W-1:0] sp_reg;
    logic [39:0]     word_buf_reg;
    logic [2:0]      word_len_reg;
    logic            word_long_reg;

    st_t             below1;
    st_t             below2;
    logic [SP_W-1:0] sp_next;

    work_t       w;
    logic [39:0] wb;
    logic [2:0]  wl;
    logic        wlong;

    function automatic work_t f_push(work_t wi, st_t s);
        work_t r;
        r = wi;
        if (wi.sp == SP_FULL) begin
            r.res = emit_res(wi.res, EV_ERROR, 8'h00);
            r.top = ST_ERROR;
        end else begin
            r.we    = 1'b1;
            r.waddr = wi.sp;
            r.wdata = wi.top;
            r.sp    = wi.sp + SP_ONE;
            r.b2    = wi.b1;
            r.b1    = wi.top;
            r.top   = s;
        end
        return r;
    endfunction

    function automatic work_t f_pop(work_t wi);
        work_t r;
        r = wi;
        if (wi.sp != '0) begin
            r.sp  = wi.sp - SP_ONE;
            r.top = wi.b1;
            r.b1  = wi.b2;
            r.b2  = ST_UNKNOWN;
        end
        return r;
    endfunction

    always_comb begin
        logic   again;
        event_t wev;
        w       = '0;
        w.top   = top_reg;
        w.b1    = below1;
        w.b2    = below2;
        w.sp    = sp_reg;
        w.waddr = sp_reg;
        w.wdata = top_reg;
        wb      = word_buf_reg;
        wl      = word_len_reg;
        wlong   = word_long_reg;
        again   = 1'b0;
        wev     = EV_ERROR;

        if (end_of_stream) begin
            if (top_reg == ST_NUMERIC) begin
                w.res = emit_res(w.res, EV_NUMEND, 8'h00);
            end else if (top_reg == ST_RESERVED) begin
                w.res = emit_res(w.res, word_event(wb, wl, wlong), 8'h00);
            end
            w.res = emit_res(w.res, EV_END, 8'h00);
            w.top = ST_UNKNOWN;
            w.sp  = '0;
            wb    = '0;
            wl    = '0;
            wlong = 1'b0;
        end else begin
            again = 1'b1;
            // A byte that ends a number or a recognized word is dispatched again to the enclosing state.
            for (int pass = 0; pass < PASSES; pass++) begin
                if (again) begin
                    again = 1'b0;
                    unique case (w.top)
                        ST_UNKNOWN: begin
                            w     = f_push(w, ST_DETECT);
                            again = (w.top == ST_DETECT);
                        end
                        ST_DETECT: begin
                            if (!is_space(in_byte)) begin
                                if (in_byte == CH_LBRACK) begin
                                    w.res = emit_res(w.res, EV_BEGARR, 8'h00);
                                    w.top = ST_ARRAY;
                                end else if (in_byte == CH_LBRACE) begin
                                    w.res = emit_res(w.res, EV_BEGOBJ, 8'h00);
                                    w.top = ST_OBJECT;
                                end else if (in_byte == CH_QUOTE) begin
                                    w.top = ST_STRING;
                                end else if (is_numch(in_byte)) begin
                                    w.top = ST_NUMERIC;
                                    again = 1'b1;
                                end else if (is_alpha(in_byte)) begin
                                    w.top = ST_RESERVED;
                                    wb    = '0;
                                    wl    = '0;
                                    wlong = 1'b0;
                                    again = 1'b1;
                                end else begin
                                    w.res = emit_res(w.res, EV_ERROR, 8'h00);
                                    w.top = ST_ERROR;
                                end
                            end
                        end
                        ST_OBJECT: begin
                            if (in_byte == CH_RBRACE) begin
                                w.res = emit_res(w.res, EV_ENDOBJ, 8'h00);
                                w     = f_pop(w);
                            end else if (in_byte == CH_QUOTE) begin
                                w = f_push(w, ST_KEY);
                            end else if ((in_byte != CH_COMMA) && !is_space(in_byte)) begin
                                w.res = emit_res(w.res, EV_ERROR, 8'h00);
                                w.top = ST_ERROR;
                            end
                        end
                        ST_ARRAY: begin
                            if (in_byte == CH_RBRACK) begin
                                w.res = emit_res(w.res, EV_ENDARR, 8'h00);
                                w     = f_pop(w);
                            end else if ((in_byte != CH_COMMA) && !is_space(in_byte)) begin
                                w     = f_push(w, ST_DETECT);
                                again = (w.top == ST_DETECT);
                            end
                        end
                        ST_KEY: begin
                            if (in_byte == CH_QUOTE) begin
                                w.res = emit_res(w.res, EV_KEYEND, 8'h00);
                                w.top = ST_DETECT;
                                w     = f_push(w, ST_PAIRSEP);
                            end else begin
                                w.res = emit_res(w.res, EV_KEYCH, in_byte);
                            end
                        end
                        ST_STRING: begin
                            if (in_byte == CH_QUOTE) begin
                                w.res = emit_res(w.res, EV_STREND, 8'h00);
                                w     = f_pop(w);
                            end else begin
                                w.res = emit_res(w.res, EV_STRCH, in_byte);
                                if (in_byte == CH_BSLASH) begin
                                    w = f_push(w, ST_ESCAPE);
                                end
                            end
                        end
                        ST_NUMERIC: begin
                            if (is_numch(in_byte)) begin
                                w.res = emit_res(w.res, EV_NUMCH, in_byte);
                            end else begin
                                w.res = emit_res(w.res, EV_NUMEND, 8'h00);
                                w     = f_pop(w);
                                again = 1'b1;
                            end
                        end
                        ST_RESERVED: begin
                            if (is_alpha(in_byte)) begin
                                if (wl < 3'(WORD_MAX)) begin
                                    for (int i = 0; i < WORD_MAX; i++) begin
                                        if (wl == 3'(i)) begin
                                            wb[8*i +: 8] = in_byte;
                                        end
                                    end
                                    wl = wl + 3'd1;
                                end else begin
                                    wlong = 1'b1;
                                end
                            end else begin
                                wev   = word_event(wb, wl, wlong);
                                w.res = emit_res(w.res, wev, 8'h00);
                                if (wev == EV_ERROR) begin
                                    w.top = ST_ERROR;
                                end else begin
                                    w     = f_pop(w);
                                    again = 1'b1;
                                end
                            end
                        end
                        ST_ESCAPE: begin
                            w.res = emit_res(w.res, EV_STRCH, in_byte);
                            w     = f_pop(w);
                        end
                        ST_PAIRSEP: begin
                            if (in_byte == CH_COLON) begin
                                w = f_pop(w);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        if (w.res.count == 2'd1) begin
            w.res.r0.last = 1'b1;
        end else if (w.res.count == 2'd2) begin
            w.res.r1.last = 1'b1;
        end
    end

    assign step    = w.res;
    assign sp_next = fire ? w.sp : sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg       <= ST_UNKNOWN;
            sp_reg        <= '0;
            word_buf_reg  <= '0;
            word_len_reg  <= '0;
            word_long_reg <= 1'b0;
        end else if (fire) begin
            top_reg       <= w.top;
            sp_reg        <= w.sp;
            word_buf_reg  <= wb;
            word_len_reg  <= wl;
            word_long_reg <= wlong;
        end
    end

    // The two read ports always track the entries just below the coming top.
    jtsp_stack #(
        .DEPTH(MAX_NESTING)
    ) u_stack (
        .aclk    (aclk),
        .we      (fire && w.we),
        .waddr   (w.waddr),
        .wdata   (w.wdata),
        .raddr_a (sp_next - SP_ONE),
        .raddr_b (sp_next - SP_TWO),
        .rdata_a (below1),
        .rdata_b (below2)
    );

endmodule

FILE: rtl/jtsp_result_queue.sv
// Four-entry result queue that takes up to two events per step and releases one per transfer.
// Depends on jtsp_pkg for the result and step types.
`timescale 1ns / 1ps

module jtsp_result_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jtsp_pkg::step_t step,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output jtsp_pkg::res_t  head
);
    import jtsp_pkg::*;

    res_t             entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic [QAW:0]     count_next;
    logic             pop;
    logic [QAW:0]     push_cnt;

    assign pop      = m_valid && m_ready;
    assign push_cnt = push ? (QAW+1)'(step.count) : '0;
    assign count_next = count_reg + push_cnt - (QAW+1)'(pop);

    // Room for a whole step, judged on the registered count alone.
    assign room    = (count_reg <= (QAW+1)'(QDEPTH - MAX_RES));
    assign m_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && (step.count != 2'd0)) begin
            entry_reg[wr_ptr_reg] <= step.r0;
        end
        if (push && (step.count == 2'd2)) begin
            entry_reg[wr_ptr_reg + QAW'(1)] <= step.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[QAW-1:0];
            rd_ptr_reg <= rd_ptr_reg + QAW'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

FILE: verif/tb_json_token_stream_parser_core.sv
// Self-checking testbench for json_token_stream_parser_core.
// Needs jtsp_pkg and the core; it predicts the tokenizer events of every accepted byte itself.
`timescale 1ns / 1ps

module tb_json_token_stream_parser_core;

    import jtsp_pkg::*;

    localparam int NEST_DEPTH    = 64;
    localparam int TEXT_ITEMS    = 180;   // input transfers wanted over the whole run
    localparam int SETTLE_CYCLES = 16;    // quiet time at the end, well past the core's latency
    localparam int WORD_BYTES    = 5;
    localparam int STEP_EVENTS   = 4;     // cap on the events one byte may add to the prediction

    // Tracks the parser's nesting stack and bare-word buffer, predicts the events of each
    // accepted byte and holds them, in order, until the result channel delivers them.
    class json_event_board;
        st_t         nest [NEST_DEPTH];
        int          top_idx;
        logic [39:0] word_buf;
        logic [2:0]  word_len;
        logic        word_long;
        res_t        step_events[$];
        res_t        expected_events[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (nest[i]) nest[i] = ST_UNKNOWN;
            top_idx   = 0;
            word_buf  = '0;
            word_len  = '0;
            word_long = 1'b0;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void add_event(event_t ev, logic [7:0] d);
            res_t r;
            if (step_events.size() < STEP_EVENTS) begin
                r.ev   = ev;
                r.data = d;
                r.last = 1'b0;
                step_events.push_back(r);
            end
        endfunction

        // A full stack turns the current top into the error state.
        function bit push_nest(st_t s);
            if (top_idx + 1 < NEST_DEPTH) begin
                top_idx++;
                nest[top_idx] = s;
                return 1'b1;
            end
            add_event(EV_ERROR, 8'h00);
            nest[top_idx] = ST_ERROR;
            return 1'b0;
        endfunction

        function void pop_nest();
            if (top_idx > 0) top_idx--;
        endfunction

        function bit is_ws(logic [7:0] c);
            return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_num_char(logic [7:0] c);
            return (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2B ||
                   c == 8'h65 || c == 8'h45 || c == 8'h2E;
        endfunction

        // Closes a bare word; only a recognized word pops its level.
        function bit close_word();
            event_t ev;
            ev = EV_ERROR;
            if (!word_long) begin
                if (word_len == 3'd4 && word_buf == WORD_TRUE) begin
                    ev = EV_TRUE;
                end else if (word_len == 3'd5 && word_buf == WORD_FALSE) begin
                    ev = EV_FALSE;
                end else if (word_len == 3'd4 && word_buf == WORD_NULL) begin
                    ev = EV_NULL;
                end
            end
            add_event(ev, 8'h00);
            if (ev == EV_ERROR) begin
                nest[top_idx] = ST_ERROR;
                return 1'b0;
            end
            pop_nest();
            return 1'b1;
        endfunction

        // Works out the events of one accepted byte and queues them; returns their number.
        function int note_input(logic [7:0] c, logic eos);
            bit again;
            int pass;
            int n;
            step_events.delete();
            if (eos) begin
                if (nest[top_idx] == ST_NUMERIC) begin
                    add_event(EV_NUMEND, 8'h00);
                end else if (nest[top_idx] == ST_RESERVED) begin
                    void'(close_word());
                end
                add_event(EV_END, 8'h00);
                clear();
            end else begin
                again = 1'b1;
                for (pass = 0; pass < 8 && again; pass++) begin
                    again = 1'b0;
                    case (nest[top_idx])
                        ST_UNKNOWN: begin
                            again = push_nest(ST_DETECT);
                        end
                        ST_DETECT: begin
                            if (is_ws(c)) begin
                            end else if (c == CH_LBRACK) begin
                                add_event(EV_BEGARR, 8'h00);
                                nest[top_idx] = ST_ARRAY;
                            end else if (c == CH_LBRACE) begin
                                add_event(EV_BEGOBJ, 8'h00);
                                nest[top_idx] = ST_OBJECT;
                            end else if (c == CH_QUOTE) begin
                                nest[top_idx] = ST_STRING;
                            end else if (is_num_char(c)) begin
                                nest[top_idx] = ST_NUMERIC;
                                again = 1'b1;
                            end else if (is_letter(c)) begin
                                nest[top_idx] = ST_RESERVED;
                                word_buf  = '0;
                                word_len  = '0;
                                word_long = 1'b0;
                                again = 1'b1;
                            end else begin
                                add_event(EV_ERROR, 8'h00);
                                nest[top_idx] = ST_ERROR;
                            end
                        end
                        ST_OBJECT: begin
                            if (c == CH_RBRACE) begin
                                add_event(EV_ENDOBJ, 8'h00);
                                pop_nest();
                            end else if (c == CH_QUOTE) begin
                                void'(push_nest(ST_KEY));
                            end else if (c != CH_COMMA && !is_ws(c)) begin
                                add_event(EV_ERROR, 8'h00);
                                nest[top_idx] = ST_ERROR;
                            end
                        end
                        ST_ARRAY: begin
                            if (c == CH_RBRACK) begin
                                add_event(EV_ENDARR, 8'h00);
                                pop_nest();
                            end else if (c != CH_COMMA && !is_ws(c)) begin
                                again = push_nest(ST_DETECT);
                            end
                        end
                        ST_KEY: begin
                            if (c == CH_QUOTE) begin
                                add_event(EV_KEYEND, 8'h00);
                                nest[top_idx] = ST_DETECT;
                                void'(push_nest(ST_PAIRSEP));
                            end else begin
                                add_event(EV_KEYCH, c);
                            end
                        end
                        ST_STRING: begin
                            if (c == CH_QUOTE) begin
                                add_event(EV_STREND, 8'h00);
                                pop_nest();
                            end else begin
                                add_event(EV_STRCH, c);
                                if (c == CH_BSLASH) void'(push_nest(ST_ESCAPE));
                            end
                        end
                        ST_NUMERIC: begin
                            if (is_num_char(c)) begin
                                add_event(EV_NUMCH, c);
                            end else begin
                                add_event(EV_NUMEND, 8'h00);
                                pop_nest();
                                again = 1'b1;
                            end
                        end
                        ST_RESERVED: begin
                            if (is_letter(c)) begin
                                if (word_len < WORD_BYTES) begin
                                    word_buf[8 * word_len +: 8] = c;
                                    word_len++;
                                end else begin
                                    word_long = 1'b1;
                                end
                            end else begin
                                again = close_word();
                            end
                        end
                        ST_ESCAPE: begin
                            add_event(EV_STRCH, c);
                            pop_nest();
                        end
                        ST_PAIRSEP: begin
                            if (c == CH_COLON) pop_nest();
                        end
                        default: begin
                        end
                    endcase
                end
            end
            n = step_events.size();
            if (n > 0) step_events[n - 1].last = 1'b1;
            foreach (step_events[i]) expected_events.push_back(step_events[i]);
            return n;
        endfunction

        // Compares one delivered event with the oldest one still expected.
        function void check_result(res_t got);
            res_t want;
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected event, expected none, got event %0d data %02h",
                         $time, got.ev, got.data);
            end else begin
                want = expected_events.pop_front();
                if (got.ev !== want.ev) begin
                    errors++;
                    $display("%0t: event mismatch, expected %0d, got %0d",
                             $time, want.ev, got.ev);
                end
                if (got.data !== want.data) begin
                    errors++;
                    $display("%0t: data mismatch, expected %02h, got %02h",
                             $time, want.data, got.data);
                end
                if (got.last !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, got.last);
                end
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte       = 8'h00;
    logic       s_end_of_stream = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [3:0] m_event_res;
    logic [7:0] m_data_byte;
    logic       m_last;

    json_event_board board = new();

    // Text of the document being built; the sender streams it and then the end mark.
    logic [7:0] doc_text[$];

    // Upper bounds of the per-transfer idle draws, changed now and then so that slow
    // stretches alternate with back-to-back traffic on either side.
    int send_gap_max = 14;
    int recv_gap_max = 14;

    // Every input transfer, end marks included, counts toward TEXT_ITEMS.
    int sent_items = 0;

    json_token_stream_parser_core #(
        .MAX_NESTING(NEST_DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_stream(s_end_of_stream),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_data_byte    (m_data_byte),
        .m_last         (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: before every transfer, hold m_ready low for a random number of cycles,
    // then keep it high until the core presents an event.
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Every event transfer is checked at the edge where it happens. Values read here
    // are the ones from before the edge, since the core and the drivers both update
    // through nonblocking assignments.
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_valid && m_ready) begin
            got.ev   = event_t'(m_event_res);
            got.data = m_data_byte;
            got.last = m_last;
            board.check_result(got);
        end
    end

    // ---------------------------------------------------------------- text generation

    function automatic void put(logic [7:0] c);
        doc_text.push_back(c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) doc_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic void put_space();
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) put(ws_char());
        end
    endfunction

    function automatic logic [7:0] letter();
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h41, 8'h5A));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // A string or key body: mostly printable, sometimes any byte but a quote. Only strings get the
    // backslash rule, where the byte after it (a quote too) passes through.
    function automatic void put_string(bit is_key);
        logic [7:0] c;
        put(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            do begin
                if ($urandom_range(0, 3) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end else begin
                    c = 8'($urandom_range(8'h20, 8'h7E));
                end
            end while (c == CH_QUOTE);
            put(c);
            if (!is_key && c == CH_BSLASH) put(8'($urandom_range(0, 255)));
        end
        if (!is_key && $urandom_range(0, 3) == 0) begin
            put(CH_BSLASH);
            put(($urandom_range(0, 1) == 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
        end
        put(CH_QUOTE);
    endfunction

    function automatic void put_number();
        string num_set;
        num_set = "-+0123456789eE.";
        repeat ($urandom_range(1, 5)) put(num_set[$urandom_range(0, 14)]);
    endfunction

    function automatic void put_word();
        case ($urandom_range(0, 2))
            0: put_str("true");
            1: put_str("false");
            default: put_str("null");
        endcase
    endfunction

    // One well-formed value; containers only near the top so documents stay short.
    function automatic void put_value(int depth);
        int kind;
        int cnt;
        logic [7:0] c;
        kind = (depth < 3) ? $urandom_range(0, 5) : $urandom_range(2, 5);
        case (kind)
            0: begin
                put(CH_LBRACE);
                put_space();
                cnt = $urandom_range(0, 3);
                for (int k = 0; k < cnt; k++) begin
                    if (k > 0) begin
                        put(CH_COMMA);
                        put_space();
                    end
                    put_string(1'b1);
                    // Anything but a colon between a key and its colon is skipped.
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(1, 3)) begin
                            do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
                            put(c);
                        end
                    end else begin
                        put_space();
                    end
                    put(CH_COLON);
                    put_space();
                    put_value(depth + 1);
                    put_space();
                end
                put(CH_RBRACE);
            end
            1: begin
                put(CH_LBRACK);
                put_space();
                cnt = $urandom_range(0, 3);
                for (int k = 0; k < cnt; k++) begin
                    if (k > 0) begin
                        put(CH_COMMA);
                        put_space();
                    end
                    put_value(depth + 1);
                    put_space();
                end
                put(CH_RBRACK);
            end
            2: put_string(1'b0);
            3: put_number();
            default: put_word();
        endcase
    endfunction

    function automatic void put_document();
        put_space();
        put_value(0);
        put_space();
        if ($urandom_range(0, 4) == 0) begin
            put(8'h20);
            put_value(0);
        end
    endfunction

    // Bare words that must fail: unknown letters, a known word with one letter changed,
    // a known word with extra letters, and upper case.
    function automatic void put_bad_word();
        string w;
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 7)) put(letter());
            1: begin
                case ($urandom_range(0, 2))
                    0: w = "true";
                    1: w = "false";
                    default: w = "null";
                endcase
                w[$urandom_range(0, w.len() - 1)] = letter();
                put_str(w);
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: put_str("falsex");
                    1: put_str("truetrue");
                    default: put_str("nulll");
                endcase
            end
            default: put_str("TRUE");
        endcase
        case ($urandom_range(0, 3))
            0: put(8'h20);
            1: put(CH_COMMA);
            2: put(CH_RBRACK);
            default: ;
        endcase
    endfunction

    // Arrays opened until the stack holds its last free level, then one more level that
    // does not fit: either a further array or, inside a new object, a key.
    function automatic void put_overflow(bit via_key);
        repeat (NEST_DEPTH - 2) put(CH_LBRACK);
        if (via_key) begin
            put(CH_LBRACE);
            put(CH_QUOTE);
        end else begin
            put(CH_LBRACK);
            put(CH_LBRACK);
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // One input transfer: an optional idle stretch, then valid held with a steady
    // payload until the core takes it. The prediction is made at the accepting edge.
    task automatic send_item(logic [7:0] c, logic eos);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_in_byte       <= c;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(board.note_input(c, eos));
        sent_items++;
    endtask

    // Streams the built document and closes it with the end mark, whose byte is random.
    task automatic send_text();
        foreach (doc_text[i]) begin
            send_item(doc_text[i], 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        doc_text.delete();
    endtask

    // Stops sending until the core has delivered every event still expected.
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() > 0);
    endtask

    task automatic pick_pace();
        case ($urandom_range(0, 3))
            0: begin
                send_gap_max = 14;
                recv_gap_max = 14;
            end
            1: begin
                send_gap_max = 0;
                recv_gap_max = 0;
            end
            2: begin
                send_gap_max = 14;
                recv_gap_max = 0;
            end
            default: begin
                send_gap_max = 0;
                recv_gap_max = 14;
            end
        endcase
    endtask

    // ---------------------------------------------------------------- test sequence

    initial begin
        int docs;
        int keep;
        bit drained;
        docs    = 0;
        drained = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed documents. The first holds an object with a key made of a backslash,
        // a zero byte skipped before the colon, null and a number ended by a comma and
        // by a bracket. The second is a string with an escaped quote and a 0xFF byte,
        // followed by a bare word that only the end mark closes. Then a number that the
        // end mark closes, and a tab, a byte that cannot start a value and a byte
        // ignored in the error state.
        put(CH_LBRACE);
        put(CH_QUOTE);
        put(CH_BSLASH);
        put(CH_QUOTE);
        put(8'h00);
        put(CH_COLON);
        put_str("[null,-E]}");
        send_text();
        put(CH_QUOTE);
        put(CH_BSLASH);
        put(CH_QUOTE);
        put(8'hFF);
        put(CH_QUOTE);
        put_str("true");
        send_text();
        put_str("7");
        send_text();
        put(8'h09);
        put_str("@x");
        send_text();
        wait_drain();

        // Nesting filled to the last level and then pushed one level past it.
        pick_pace();
        put_overflow($urandom_range(0, 1) == 1);
        send_text();

        // Random documents: mostly well-formed with random content, the rest cut short,
        // corrupted in one byte, bad bare words or plain noise.
        while (sent_items < TEXT_ITEMS) begin
            if (docs % 4 == 0) pick_pace();
            case ($urandom_range(0, 99)) inside
                [0:69]: put_document();
                [70:79]: begin
                    put_document();
                    if (doc_text.size() > 1) begin
                        keep = $urandom_range(1, doc_text.size() - 1);
                        while (doc_text.size() > keep) void'(doc_text.pop_back());
                    end
                end
                [80:87]: begin
                    put_document();
                    doc_text[$urandom_range(0, doc_text.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
                [88:93]: begin
                    put_space();
                    put_bad_word();
                end
                default: repeat ($urandom_range(3, 12)) put(8'($urandom_range(0, 255)));
            endcase
            send_text();
            docs++;
            if (!drained && sent_items >= (TEXT_ITEMS * 3) / 4) begin
                wait_drain();
                drained = 1'b1;
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_json_token_stream_parser_core: done, clean");
        end else begin
            $display("tb_json_token_stream_parser_core: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run of this stimulus.
    initial begin
        #(5_000_000);
        $display("tb_json_token_stream_parser_core: done, errors");
        $finish;
    end

endmodule
